// ===== rtl/core/lzsswd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lzsswd_pkg: shared types and constants of the LZSS window decompressor
// Token command format passed from the parser to the copy engine, parse
// phases and stream format constants.
// ---------------------------------------------------------------------------
package lzsswd_pkg;

    // Stream format
    localparam int unsigned LZ_WINDOW_SIZE     = 4096;
    localparam int unsigned LZ_OFFSET_W        = 12;
    localparam int unsigned LZ_LEN_W           = 4;
    localparam int unsigned LZ_LEFT_W          = 5;
    localparam int unsigned LZ_MIN_MATCH       = 3;
    localparam int unsigned LZ_START_BACK      = 18;
    localparam int unsigned LZ_FLAGS_PER_BYTE  = 8;
    localparam int unsigned LZ_SIZE_W          = 32;
    localparam logic [LZ_SIZE_W-1:0] LZ_SIZE_RESET = 32'd1;

    // Command queue depth between parser and engine
    localparam int unsigned LZ_FIFO_DEPTH      = 4;

    // Parser phase
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_MATCH_HI
    } phase_t;

    // Command kinds
    typedef enum logic [1:0] {
        CMD_RESTART,
        CMD_LITERAL,
        CMD_MATCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [7:0]              data;
        logic [LZ_OFFSET_W-1:0]  offset;
        logic [LZ_LEN_W-1:0]     len_code;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/lzss_window_decompressor_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lzss_window_decompressor_top: LZSS decompressor, 4 KB window
// Parser front end, command queue and window copy engine.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one compressed byte per beat;
//   stream_start on a beat restarts the stream with that byte as flag byte.
//   Output channel (out_valid/out_ready): one decompressed byte per beat,
//   last marks the byte that reaches output_size; later input is dropped
//   until the next stream_start.
//   Config channel (cfg_valid/cfg_ready): writes output_size, always ready;
//   write it only while the block is idle. Resets to 1.
// Timing:
//   A literal passes the command queue, the write/emit stage and the output
//   register. A match gives one byte per cycle unless the output stalls, set
//   by the single read port of the window memory; flag bytes cost no engine
//   time. A 4-entry command queue lets input run ahead of the engine.
// Reset and stalls:
//   No clearing pass: a fill count marks unwritten window entries as zero,
//   so the block takes input from the first cycle after reset. When the
//   receiver stalls, the output beat holds, the engine stops, and in_ready
//   drops once the queue is full.
// ---------------------------------------------------------------------------
module lzss_window_decompressor_top
    import lzsswd_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = LZ_WINDOW_SIZE
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           comp_byte,
    input  wire logic                 stream_start,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_byte,
    output logic                      last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [LZ_SIZE_W-1:0] cfg_data
);

    logic [LZ_SIZE_W-1:0] output_size_reg;
    logic                 q_full, q_push, q_pop, q_valid;
    cmd_t                 q_in, q_out;

    // size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_size_reg <= LZ_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            output_size_reg <= cfg_data;
        end
    end

    lzsswd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .comp_byte    (comp_byte),
        .stream_start (stream_start),
        .cmd_full     (q_full),
        .cmd_push     (q_push),
        .cmd          (q_in)
    );

    lzsswd_cmd_fifo #(
        .DEPTH (LZ_FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    lzsswd_engine #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd         (q_out),
        .cmd_pop     (q_pop),
        .output_size (output_size_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last        (last)
    );

endmodule
`default_nettype wire

// ===== rtl/core/lzsswd_parser.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lzsswd_parser: compressed byte parser
// Accepts one compressed byte per beat, tracks flag bits and match halves,
// and pushes one command per literal, match or stream restart.
// ---------------------------------------------------------------------------
module lzsswd_parser
    import lzsswd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] comp_byte,
    input  wire logic       stream_start,
    input  wire logic       cmd_full,
    output logic            cmd_push,
    output cmd_t            cmd
);

    phase_t      phase_reg, phase_next;
    phase_t      eff_phase;
    logic [7:0]  flags_reg, flags_next;
    logic [3:0]  left_reg, left_next;
    logic [3:0]  left_dec;
    logic [7:0]  low_reg, low_next;
    logic        accept;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && in_ready;

    // a restart forces the byte to be read as a flag byte
    assign eff_phase = stream_start ? PH_FLAG : phase_reg;
    assign left_dec  = (left_reg != 4'd0) ? (left_reg - 4'd1) : 4'd0;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        left_next  = left_reg;
        low_next   = low_reg;
        if (accept)
        begin
            case (eff_phase)
                PH_FLAG:
                begin
                    flags_next = comp_byte;
                    left_next  = 4'(LZ_FLAGS_PER_BYTE);
                    phase_next = PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    if (flags_reg[0])
                    begin
                        flags_next = flags_reg >> 1;
                        left_next  = left_dec;
                        phase_next = (left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
                    end
                    else
                    begin
                        low_next   = comp_byte;
                        phase_next = PH_MATCH_HI;
                    end
                end
                PH_MATCH_HI:
                begin
                    flags_next = flags_reg >> 1;
                    left_next  = left_dec;
                    phase_next = (left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
                end
                default:
                begin
                    phase_next = PH_FLAG;
                end
            endcase
        end
    end

    // command output
    always_comb
    begin
        cmd.kind     = CMD_RESTART;
        cmd.data     = comp_byte;
        cmd.offset   = {comp_byte[7:4], low_reg};
        cmd.len_code = comp_byte[3:0];
        cmd_push     = 1'b0;
        if (accept)
        begin
            if (stream_start)
            begin
                cmd_push = 1'b1;
                cmd.kind = CMD_RESTART;
            end
            else
            begin
                case (phase_reg)
                    PH_TOKEN:
                    begin
                        cmd_push = flags_reg[0];
                        cmd.kind = CMD_LITERAL;
                    end
                    PH_MATCH_HI:
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_MATCH;
                    end
                    default:
                    begin
                        cmd_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAG;
            flags_reg <= 8'h00;
            left_reg  <= 4'd0;
            low_reg   <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            left_reg  <= left_next;
            low_reg   <= low_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lzsswd_cmd_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lzsswd_cmd_fifo: command queue
// Short register queue that decouples the parser from the copy engine.
// ---------------------------------------------------------------------------
module lzsswd_cmd_fifo
    import lzsswd_pkg::*;
#(
    parameter int unsigned DEPTH = LZ_FIFO_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : (wr_ptr_reg + AW'(1));
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : (rd_ptr_reg + AW'(1));
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lzsswd_engine.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lzsswd_engine: window copy engine
// Executes commands: literals and match copies through the history window,
// one byte per cycle unless the output stalls, with a registered output stage.
// ---------------------------------------------------------------------------
module lzsswd_engine
    import lzsswd_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = LZ_WINDOW_SIZE
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    input  wire cmd_t                 cmd,
    output logic                      cmd_pop,
    input  wire logic [LZ_SIZE_W-1:0] output_size,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_byte,
    output logic                      last
);

    localparam int unsigned AW = $clog2(WINDOW_SIZE);
    localparam int unsigned FW = AW + 1;
    localparam logic [AW-1:0] START_PTR = AW'(WINDOW_SIZE - LZ_START_BACK);
    localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_SIZE);

    // history window
    logic [7:0]           win_mem [WINDOW_SIZE];
    logic [7:0]           rd_q_reg;

    logic [AW-1:0]        wp_reg;
    logic [FW-1:0]        fill_reg;
    logic [LZ_SIZE_W-1:0] count_reg;
    logic                 finished_reg;
    logic [AW-1:0]        src_reg;
    logic [LZ_LEFT_W-1:0] left_reg;

    // write/emit stage
    logic                 w_valid_reg;
    logic                 w_from_mem_reg;
    logic [7:0]           w_data_reg;

    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 last_reg;

    logic                 out_free, w_emit, w_take, w_open;
    logic [7:0]           w_byte;
    logic [LZ_SIZE_W-1:0] count_inc;
    logic                 is_last;
    logic [FW-1:0]        fill_inc, fill_eff;
    logic [AW-1:0]        rd_dist;
    logic                 rd_written, rd_fwd, busy, rd_issue;
    logic                 do_restart, do_literal, do_match;

    assign out_free  = !out_valid_reg || out_ready;
    assign w_byte    = w_from_mem_reg ? rd_q_reg : w_data_reg;
    assign w_emit    = w_valid_reg && !finished_reg && out_free;
    assign w_take    = w_valid_reg && (finished_reg || out_free);
    assign w_open    = !w_valid_reg || w_take;

    assign count_inc = count_reg + LZ_SIZE_W'(1);
    assign is_last   = (count_inc == output_size);

    // bytes written since stream start, saturating; unwritten entries read as zero
    assign fill_inc   = (fill_reg == FILL_FULL) ? fill_reg : (fill_reg + FW'(1));
    assign fill_eff   = w_emit ? fill_inc : fill_reg;
    assign rd_dist    = src_reg - START_PTR;
    assign rd_written = ({1'b0, rd_dist} < fill_eff);
    // read of the entry being written this cycle
    assign rd_fwd     = w_emit && (wp_reg == src_reg);

    assign busy     = (left_reg != '0);
    assign rd_issue = busy && !finished_reg && w_open;

    // command pop
    always_comb
    begin
        cmd_pop = 1'b0;
        if (cmd_valid && !busy)
        begin
            case (cmd.kind)
                CMD_RESTART: cmd_pop = !w_valid_reg;
                CMD_LITERAL: cmd_pop = finished_reg || w_open;
                CMD_MATCH:   cmd_pop = 1'b1;
                default:     cmd_pop = 1'b1;
            endcase
        end
    end

    assign do_restart = cmd_pop && (cmd.kind == CMD_RESTART);
    assign do_literal = cmd_pop && (cmd.kind == CMD_LITERAL) && !finished_reg;
    assign do_match   = cmd_pop && (cmd.kind == CMD_MATCH) && !finished_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= START_PTR;
            fill_reg      <= '0;
            count_reg     <= '0;
            finished_reg  <= 1'b0;
            src_reg       <= '0;
            left_reg      <= '0;
            w_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_restart)
            begin
                wp_reg       <= START_PTR;
                fill_reg     <= '0;
                count_reg    <= '0;
                finished_reg <= 1'b0;
            end
            else if (w_emit)
            begin
                wp_reg    <= wp_reg + AW'(1);
                fill_reg  <= fill_inc;
                count_reg <= count_inc;
                if (is_last)
                begin
                    finished_reg <= 1'b1;
                end
            end

            // match walk, cut short once the stream is done
            if (finished_reg)
            begin
                left_reg <= '0;
            end
            else if (do_match)
            begin
                src_reg  <= AW'(cmd.offset);
                left_reg <= LZ_LEFT_W'(cmd.len_code) + LZ_LEFT_W'(LZ_MIN_MATCH);
            end
            else if (rd_issue)
            begin
                src_reg  <= src_reg + AW'(1);
                left_reg <= left_reg - LZ_LEFT_W'(1);
            end

            if (do_literal || rd_issue)
            begin
                w_valid_reg <= 1'b1;
            end
            else if (w_take)
            begin
                w_valid_reg <= 1'b0;
            end

            out_valid_reg <= w_emit || (out_valid_reg && !out_ready);
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (do_literal)
        begin
            w_from_mem_reg <= 1'b0;
            w_data_reg     <= cmd.data;
        end
        else if (rd_issue)
        begin
            w_from_mem_reg <= !rd_fwd && rd_written;
            w_data_reg     <= rd_fwd ? w_byte : 8'h00;
        end
        if (w_emit)
        begin
            out_byte_reg <= w_byte;
            last_reg     <= is_last;
        end
    end

    // window memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (w_emit)
        begin
            win_mem[wp_reg] <= w_byte;
        end
        if (rd_issue)
        begin
            rd_q_reg <= win_mem[src_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

// ===== rtl/core/lzsswd_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lzsswd_port_checks: port-level checks for the decompressor
// Watches the top-level ports for output hold, for output beats that appear
// with no input behind them or too soon after it, and for stalled config writes.
// ---------------------------------------------------------------------------
module lzsswd_port_checks
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [7:0] out_byte,
    input wire logic last,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    logic seen_in_reg;
    logic in_beat;

    assign in_beat = in_valid && in_ready;

    // any input beat since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            seen_in_reg <= 1'b1;
        end
    end

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output beat changed while stalled");

    // no output beat before any input
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_in_reg |-> !out_valid)
        else $error("output beat with no input accepted");

    // first input passes through queue and engine before it can reach the output
    a_first_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && !seen_in_reg |=> !out_valid ##1 !out_valid)
        else $error("output beat too soon after first input");

    // config writes never stall
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind lzss_window_decompressor_top lzsswd_port_checks u_lzsswd_port_checks (.*);
`default_nettype wire

// ===== tb/lzsswd_checker.sv =====
// ---------------------------------------------------------------------------
// lzsswd_checker: output checker for the LZSS window decompressor
// Watches the config, input and output channels of the block. Every accepted
// input beat is decoded by a local model of the parser and the 4 KB history
// window. The decoded bytes are queued, and each output beat is compared with
// the oldest queued byte and its last flag.
// ---------------------------------------------------------------------------
module lzsswd_checker
    import lzsswd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [7:0]           comp_byte,
    input  wire logic                 stream_start,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [7:0]           out_byte,
    input  wire logic                 last,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [LZ_SIZE_W-1:0] cfg_data,
    output int unsigned               fail_count,
    output int unsigned               bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // Decoded bytes not yet seen at the output
    out_beat_t owed_q[$];

    // Model state
    logic [7:0]             window_mem [LZ_WINDOW_SIZE];
    logic [LZ_OFFSET_W-1:0] wr_ptr;
    logic [7:0]             flag_byte;
    logic [3:0]             flag_cnt;
    logic [7:0]             lo_offset;
    phase_t                 phase;
    logic [LZ_SIZE_W-1:0]   byte_count;
    logic [LZ_SIZE_W-1:0]   size_limit;
    logic                   stream_done;
    int unsigned            errors = 0;

    // New stream: zero window, pointer back to its start position
    task automatic clear_stream();
        foreach (window_mem[i])
            window_mem[i] = 8'h00;
        wr_ptr      = LZ_OFFSET_W'(LZ_WINDOW_SIZE - LZ_START_BACK);
        flag_byte   = 8'h00;
        flag_cnt    = 4'd0;
        lo_offset   = 8'h00;
        phase       = PH_FLAG;
        byte_count  = '0;
        stream_done = 1'b0;
    endtask

    // One decoded byte: written back into the window and queued
    task automatic put_byte(input logic [7:0] value);
        logic at_end;
        window_mem[wr_ptr] = value;
        wr_ptr             = wr_ptr + LZ_OFFSET_W'(1);
        byte_count         = byte_count + LZ_SIZE_W'(1);
        at_end             = (byte_count == size_limit);
        if (at_end)
            stream_done = 1'b1;
        owed_q.push_back('{data: value, last: at_end});
    endtask

    task automatic next_token();
        flag_byte = flag_byte >> 1;
        if (flag_cnt != 4'd0)
            flag_cnt = flag_cnt - 4'd1;
        phase = (flag_cnt != 4'd0) ? PH_TOKEN : PH_FLAG;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic restart);
        logic [LZ_OFFSET_W-1:0] src;
        int unsigned            run_len;
        int unsigned            k;
        if (restart)
            clear_stream();
        // input after the end of a stream is dropped
        if (!stream_done) begin
            case (phase)
                PH_FLAG:
                begin
                    flag_byte = b;
                    flag_cnt  = 4'(LZ_FLAGS_PER_BYTE);
                    phase     = PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    if (flag_byte[0]) begin
                        put_byte(b);
                        next_token();
                    end
                    else begin
                        lo_offset = b;
                        phase     = PH_MATCH_HI;
                    end
                end
                PH_MATCH_HI:
                begin
                    // byte by byte, so overlapping copies repeat data;
                    // a match is cut where the stream ends
                    src     = {b[7:4], lo_offset};
                    run_len = b[3:0] + LZ_MIN_MATCH;
                    for (k = 0; k < run_len && !stream_done; k++)
                        put_byte(window_mem[src + LZ_OFFSET_W'(k)]);
                    next_token();
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Compare output beats, then apply config and input beats of this edge
    always @(posedge clk or negedge rst_n) begin
        out_beat_t want;
        if (!rst_n) begin
            size_limit = LZ_SIZE_RESET;
            clear_stream();
            owed_q.delete();
            errors = 0;
            fail_count <= 0;
            bytes_owed <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (owed_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: output beat with none expected, got byte %02h last %0b",
                             $time, out_byte, last);
                end
                else begin
                    want = owed_q.pop_front();
                    if (out_byte !== want.data) begin
                        errors++;
                        $display("%0t ns: out_byte expected %02h, got %02h",
                                 $time, want.data, out_byte);
                    end
                    if (last !== want.last) begin
                        errors++;
                        $display("%0t ns: last expected %0b, got %0b (byte %02h)",
                                 $time, want.last, last, want.data);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                size_limit = cfg_data;
            if (in_valid && in_ready)
                decode_byte(comp_byte, stream_start);
            fail_count <= errors;
            bytes_owed <= owed_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: testbench top for the LZSS window decompressor
// Drives the config and input channels and the output ready, with random
// gaps and stalls and one long output stall. A short directed run covers the
// size extremes, a match cut short, a restart mid-stream and input dropped
// after the end. Random streams of flag, literal and match tokens follow.
// The checker beside the block does all checking.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzsswd_pkg::*;

    localparam int unsigned RAND_ITEMS   = 160;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned LONG_STALL   = 400;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic [7:0]           comp_byte    = 8'h00;
    logic                 stream_start = 1'b0;
    logic                 out_ready    = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic [LZ_SIZE_W-1:0] cfg_data     = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic [7:0]           out_byte;
    logic                 last;
    logic                 cfg_ready;
    int unsigned          fail_count;
    int unsigned          bytes_owed;

    // Stimulus-side view of the stream, used only to shape the tokens
    logic [LZ_OFFSET_W-1:0] gen_wp;
    logic [LZ_SIZE_W-1:0]   gen_made;
    logic [LZ_SIZE_W-1:0]   gen_size = LZ_SIZE_RESET;
    int unsigned            rand_items = 0;
    int unsigned            send_calm = 0;
    int unsigned            recv_calm = 0;
    bit                     long_stall_done = 1'b0;

    lzss_window_decompressor_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .comp_byte    (comp_byte),
        .stream_start (stream_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    lzsswd_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .comp_byte    (comp_byte),
        .stream_start (stream_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .bytes_owed   (bytes_owed)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Random wait before a beat, with runs of back-to-back beats
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = 24;
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic bit stream_over();
        return (gen_size != 0) && (gen_made >= gen_size);
    endfunction

    // One input beat; returns at the edge where it is accepted
    task automatic send_byte(input logic [7:0] b, input logic restart);
        int unsigned gap;
        gap = draw_wait(send_calm);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        comp_byte    <= b;
        stream_start <= restart;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Let the block drain, then write output_size
    task automatic write_size(input logic [LZ_SIZE_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        gen_size = value;
    endtask

    // Well-formed stream of random tokens, now and then broken off mid-match
    task automatic send_stream(input int unsigned n_tokens);
        logic [7:0]             flags;
        logic [LZ_OFFSET_W-1:0] src;
        logic [3:0]             len_code;
        int unsigned            tok;
        int unsigned            run;
        int unsigned            k;
        logic                   first;
        gen_wp   = LZ_OFFSET_W'(LZ_WINDOW_SIZE - LZ_START_BACK);
        gen_made = '0;
        tok      = 0;
        first    = 1'b1;
        while (tok < n_tokens && !stream_over()) begin
            flags = 8'($urandom);
            send_byte(flags, first);
            first = 1'b0;
            rand_items++;
            for (k = 0; k < 8 && tok < n_tokens && !stream_over(); k++) begin
                if (flags[k]) begin
                    send_byte(8'($urandom), 1'b0);
                    rand_items++;
                    gen_wp   = gen_wp + LZ_OFFSET_W'(1);
                    gen_made = gen_made + LZ_SIZE_W'(1);
                end
                else begin
                    // mostly near the write pointer, so copies hit live data
                    case ($urandom_range(0, 3))
                        0, 1:    src = gen_wp - LZ_OFFSET_W'($urandom_range(1, 20));
                        2:       src = LZ_OFFSET_W'($urandom);
                        default: src = gen_wp - LZ_OFFSET_W'($urandom_range(1, 300));
                    endcase
                    len_code = 4'($urandom);
                    send_byte(src[7:0], 1'b0);
                    rand_items++;
                    if ($urandom_range(0, 24) == 0)
                        return;
                    send_byte({src[11:8], len_code}, 1'b0);
                    rand_items++;
                    run    = len_code + LZ_MIN_MATCH;
                    gen_wp = gen_wp + LZ_OFFSET_W'(run);
                    if (gen_size != 0 && gen_size - gen_made < run)
                        gen_made = gen_size;
                    else
                        gen_made = gen_made + run;
                end
                tok++;
            end
        end
        // a few beats past the end, dropped by the block
        if (stream_over()) begin
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
        end
    endtask

    // Random bytes with occasional restarts
    task automatic send_noise(input int unsigned n);
        int unsigned k;
        send_byte(8'($urandom), 1'b1);
        for (k = 1; k < n; k++)
            send_byte(8'($urandom), $urandom_range(0, 15) == 0);
        rand_items += n;
    endtask

    // Reset and stimulus
    initial begin
        logic [LZ_SIZE_W-1:0] size;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size from reset is 1: one literal ends the stream, the next is dropped
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // largest size; flags 0x05: literal, match, literal, matches
        write_size('1);
        send_byte(8'h05, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hEE, 1'b0);     // offset 0xFEE, 18 bytes, overlaps and wraps
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);     // offset 0x000, 3 bytes
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);     // restart in the middle of the flag group
        send_byte(8'h12, 1'b0);
        send_byte(8'hF3, 1'b0);     // unwritten window, reads zeros
        send_byte(8'h34, 1'b0);     // match left half done

        // size 5 ends inside an 18-byte match; then a dropped byte, a restart
        write_size(32'd5);
        send_byte(8'h01, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'hEE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h00, 1'b1);

        // size zero never ends, nor does a size set below the count
        write_size('0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        write_size(32'd1);
        send_byte(8'h80, 1'b0);

        // random phases, each with its own size
        while (rand_items < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0:             size = 32'd1;
                1:             size = '1;
                2:             size = '0;
                3, 4, 5, 6:    size = $urandom_range(2, 40);
                7, 8:          size = $urandom_range(41, 300);
                default:       size = $urandom;
            endcase
            write_size(size);
            repeat ($urandom_range(1, 3)) begin
                if (rand_items < RAND_ITEMS) begin
                    if ($urandom_range(0, 6) == 0)
                        send_noise($urandom_range(3, 12));
                    else
                        send_stream($urandom_range(4, 30));
                end
            end
        end

        // drain and report
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && bytes_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output ready: random stalls, and one long hold-off while input is offered
    initial begin
        int unsigned gap;
        int unsigned beats;
        beats = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = draw_wait(recv_calm);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            beats++;
            if (!long_stall_done && beats >= 100 && in_valid) begin
                long_stall_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
        end
    end

    // Watchdog
    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
